// ----- sv/wdbm_pkg.sv -----
// Shared constants and helpers for the window density bit modulator.
`default_nettype none

package wdbm_pkg;

    localparam int HistBits = 64;
    localparam int BitsPerItem = 8;

    // Bits held once the history is full.
    localparam logic [6:0] HIST_FULL = 7'd64;
    // Window length base once the history is full.
    localparam logic [6:0] FULL_WINDOW_BASE = 7'd56;
    // Last decision index within one item.
    localparam logic [2:0] LAST_DECISION = 3'd7;

    // Count the ones in a byte.
    function automatic logic [3:0] pop8(input logic [7:0] v);
        logic [3:0] acc;
        acc = 4'd0;
        for (int i = 0; i < 8; i++)
        begin
            acc = acc + 4'(v[i]);
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

// ----- sv/wdbm_decide.sv -----
// Shared decision unit: compares the window level against the target level.
`default_nettype none

module wdbm_decide (
    input  wire logic signed [15:0] target,
    input  wire logic        [6:0]  win_len,
    input  wire logic        [6:0]  win_ones,
    output      logic               bit_one
);

    logic signed [8:0]  diff;
    logic signed [24:0] lhs;
    logic signed [24:0] rhs;

    // Exact form of (2*ones - n)/n < target/32768, both sides scaled by n*32768.
    always_comb
    begin
        diff = $signed({1'b0, win_ones, 1'b0}) - $signed({2'b00, win_len});
        lhs  = 25'(diff) <<< 15;
        rhs  = 25'(target) * 25'($signed({1'b0, win_len}));
        if (win_len == 7'd0)
        begin
            bit_one = (target > 16'sd0);
        end
        else
        begin
            bit_one = (lhs < rhs);
        end
    end

endmodule

`default_nettype wire

// ----- sv/window_density_bit_modulator.sv -----
// Top level of the window density bit modulator: per-channel history and sequencer.
// The accepting edge loads the item into the working registers, ST_RUN makes its decisions,
// then ST_WRITE stores; the store waits while an earlier byte is still unaccepted.
// The single decision unit makes one bit per cycle; no new item is taken until the store.
// in_ready is high only while idle; a finished byte waits in the output register meanwhile.
// Reset (rst_n low, asynchronous): every channel history, fill count and ones count is cleared,
// the sequencer returns to idle and no result is pending.
`default_nettype none

module window_density_bit_modulator #(
    parameter int CHANNELS = 2
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output      logic               in_ready,
    input  wire logic signed [15:0] target_level,
    input  wire logic               channel,
    output      logic               out_valid,
    input  wire logic               out_ready,
    output      logic        [7:0]  out_byte
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_WRITE
    } state_t;

    // Per-channel state: history, fill count, ones in history[55:0], ones in whole history.
    logic [63:0] hist_st_reg  [CHANNELS];
    logic [63:0] hist_st_next [CHANNELS];
    logic [6:0]  fill_st_reg  [CHANNELS];
    logic [6:0]  fill_st_next [CHANNELS];
    logic [5:0]  lo_st_reg    [CHANNELS];
    logic [5:0]  lo_st_next   [CHANNELS];
    logic [6:0]  all_st_reg   [CHANNELS];
    logic [6:0]  all_st_next  [CHANNELS];

    // Working registers for the item in flight.
    state_t             state_reg, state_next;
    logic [2:0]         cnt_reg, cnt_next;
    logic signed [15:0] target_reg, target_next;
    logic               ch_reg, ch_next;
    logic               range_reg, range_next;
    logic [63:0]        hist_reg, hist_next;
    logic [6:0]         fill_reg, fill_next;
    logic [6:0]         ones_lo_reg, ones_lo_next;
    logic [6:0]         ones_all_reg, ones_all_next;
    logic [3:0]         lost_reg, lost_next;
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_byte_reg, out_byte_next;

    // Selected channel state and decision unit hookup.
    logic [63:0] sel_hist;
    logic [6:0]  sel_fill;
    logic [5:0]  sel_lo;
    logic [6:0]  sel_all;
    logic        in_range;
    logic        hist_full;
    logic [6:0]  win_len;
    logic [6:0]  win_ones;
    logic        bit_one;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;

    // A channel code at or above CHANNELS touches no state and yields a zero byte.
    assign in_range = (int'(channel) < CHANNELS);

    always_comb
    begin
        sel_hist = '0;
        sel_fill = '0;
        sel_lo   = '0;
        sel_all  = '0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            if (i == int'(channel))
            begin
                sel_hist = hist_st_reg[i];
                sel_fill = fill_st_reg[i];
                sel_lo   = lo_st_reg[i];
                sel_all  = all_st_reg[i];
            end
        end
    end

    // Once the history is full the window is 56+c bits, which covers the old
    // history[55:0] plus the bits made so far in this item.  Before that it is
    // the whole history, whose upper bits are still zero.
    assign hist_full = (fill_reg >= wdbm_pkg::HIST_FULL);
    assign win_len   = hist_full ? (wdbm_pkg::FULL_WINDOW_BASE + 7'(cnt_reg)) : fill_reg;
    assign win_ones  = hist_full ? ones_lo_reg : ones_all_reg;

    wdbm_decide u_decide (
        .target   (target_reg),
        .win_len  (win_len),
        .win_ones (win_ones),
        .bit_one  (bit_one)
    );

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        target_next    = target_reg;
        ch_next        = ch_reg;
        range_next     = range_reg;
        hist_next      = hist_reg;
        fill_next      = fill_reg;
        ones_lo_next   = ones_lo_reg;
        ones_all_next  = ones_all_reg;
        lost_next      = lost_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        hist_st_next   = hist_st_reg;
        fill_st_next   = fill_st_reg;
        lo_st_next     = lo_st_reg;
        all_st_next    = all_st_reg;

        // Drop the pending result once the consumer takes it.
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    // Load the channel's state into the working registers.
                    state_next    = ST_RUN;
                    cnt_next      = '0;
                    target_next   = target_level;
                    ch_next       = channel;
                    range_next    = in_range;
                    hist_next     = sel_hist;
                    fill_next     = sel_fill;
                    ones_lo_next  = 7'(sel_lo);
                    ones_all_next = sel_all;
                    lost_next     = wdbm_pkg::pop8(sel_hist[63:56]);
                end
            end
            ST_RUN:
            begin
                // Shift one decision into the history per cycle.
                hist_next     = {hist_reg[62:0], bit_one};
                ones_lo_next  = ones_lo_reg + 7'(bit_one);
                ones_all_next = ones_all_reg + 7'(bit_one);
                if (!hist_full)
                begin
                    fill_next = fill_reg + 7'd1;
                end
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == wdbm_pkg::LAST_DECISION)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                // Hold until the output register is free, then store and publish.
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = range_reg ? hist_reg[7:0] : 8'd0;
                    if (range_reg)
                    begin
                        for (int i = 0; i < CHANNELS; i++)
                        begin
                            if (i == int'(ch_reg))
                            begin
                                hist_st_next[i] = hist_reg;
                                fill_st_next[i] = fill_reg;
                                // Old bits 55:48 now sit at 63:56 and leave the low window.
                                lo_st_next[i]   = 6'(ones_lo_reg
                                                  - 7'(wdbm_pkg::pop8(hist_reg[63:56])));
                                all_st_next[i]  = ones_all_reg - 7'(lost_reg);
                            end
                        end
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                hist_st_reg[i] <= '0;
                fill_st_reg[i] <= '0;
                lo_st_reg[i]   <= '0;
                all_st_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            hist_st_reg   <= hist_st_next;
            fill_st_reg   <= fill_st_next;
            lo_st_reg     <= lo_st_next;
            all_st_reg    <= all_st_next;
        end
    end

    // Working payload registers need no reset.
    always_ff @(posedge clk)
    begin
        cnt_reg      <= cnt_next;
        target_reg   <= target_next;
        ch_reg       <= ch_next;
        range_reg    <= range_next;
        hist_reg     <= hist_next;
        fill_reg     <= fill_next;
        ones_lo_reg  <= ones_lo_next;
        ones_all_reg <= ones_all_next;
        lost_reg     <= lost_next;
        out_byte_reg <= out_byte_next;
    end

    // Stored fill count never passes a full history.
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_st_reg[0] <= wdbm_pkg::HIST_FULL)
    else $error("channel 0 fill count above 64");

    // Ones below bit 56 can never exceed ones in the whole history.
    assert property (@(posedge clk) disable iff (!rst_n)
        7'(lo_st_reg[0]) <= all_st_reg[0])
    else $error("channel 0 ones counts inconsistent");

    // A new result appears only out of the store step.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_WRITE))
    else $error("result raised outside the store step");

    // The last decision is always followed by the store step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && cnt_reg == wdbm_pkg::LAST_DECISION) |=> state_reg == ST_WRITE)
    else $error("decision sequence did not end in store");

    // The window count during decisions stays within the window length.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && hist_full) |-> ones_lo_reg <= win_len)
    else $error("window ones exceed window length");

endmodule

`default_nettype wire
